// ===== rtl/core/omfh_pkg.sv =====
// Shared types and constants for the mutex lock manager with a FIFO of waiters.
// Holds the request and response word layouts, status codes and queue control.
// No dependencies.
package omfh_pkg;

   localparam int PID_W    = 8;
   localparam int COUNT_W  = 4;
   localparam int MISUSE_W = 32;

   // request function codes
   localparam logic FUNC_LOCK   = 1'b0;
   localparam logic FUNC_UNLOCK = 1'b1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BLOCKED     = 2'd1,
      ST_BAD_PROCESS = 2'd2,
      ST_NOT_OWNER   = 2'd3
   } status_type;

   typedef struct packed {
      logic             func;
      logic [PID_W-1:0] pid;
      logic             process_valid;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [PID_W-1:0]    woken_pid;
      logic [PID_W-1:0]    owner_now;
      logic [COUNT_W-1:0]  waiters_now;
      logic [MISUSE_W-1:0] misuse_total;
   } rsp_type;

   // one step on the wait queue: at most one of the two is set
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage

// ===== rtl/core/omfh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module omfh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/omfh_queue.sv =====
// Ring-buffer wait queue: head index, fill count and a RAM of waiting pids.
// Keeps the head entry ready every cycle. Depends on omfh_pkg and omfh_ram.
module omfh_queue #(
   parameter int DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  omfh_pkg::queue_ctl_type          ctl,
   input  logic [omfh_pkg::PID_W-1:0]       push_pid,
   output logic [omfh_pkg::PID_W-1:0]       head_pid,
   output logic [$clog2(DEPTH+1)-1:0]       count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W:0] DEPTH_X = (CNT_W + 1)'(DEPTH);
   localparam logic [IDX_W:0] LAST_X  = (IDX_W + 1)'(DEPTH - 1);

   logic [IDX_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      bypass_ff, bypass_in;
   logic [omfh_pkg::PID_W-1:0] bypass_pid_ff;
   logic [CNT_W:0]            tail_sum;
   logic [IDX_W-1:0]          tail;
   logic [omfh_pkg::PID_W-1:0] rd_data;

   // tail = (head + count) mod DEPTH; the sum stays below twice the depth
   always_comb begin
      tail_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
      if (tail_sum >= DEPTH_X) begin
         tail = IDX_W'(tail_sum - DEPTH_X);
      end else begin
         tail = IDX_W'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = ((IDX_W + 1)'(head_ff) == LAST_X) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end
      // the RAM read lags a write to the same slot: forward the written pid
      bypass_in = ctl.push && (tail == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         bypass_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         bypass_ff <= bypass_in;
      end
      bypass_pid_ff <= push_pid;
   end

   omfh_ram #(
      .WIDTH (omfh_pkg::PID_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail),
      .wr_data (push_pid),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   assign head_pid = bypass_ff ? bypass_pid_ff : rd_data;
   assign count    = count_ff;

endmodule

// ===== rtl/core/owner_mutex_fifo_handoff.sv =====
// Mutex lock manager with a FIFO of waiting processes.
// A word taken into the input register at a start edge passes through the result register
// and then shows on rsp_word with rsp_strobe.
// Throughput: one word per cycle; busy stays low, the single state update is one
// read-modify-write of owner, misuse counter and the ring-buffer queue each cycle.
// Reset (synchronous, active high): mutex free, queue empty, misuse count zero.
// The receiver cannot stall: every result shows for exactly one cycle.
module owner_mutex_fifo_handoff #(
   parameter int MAX_WAITERS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  omfh_pkg::req_type req_word,
   output logic              rsp_strobe,
   output omfh_pkg::rsp_type rsp_word
);

   localparam int CNT_W = $clog2(MAX_WAITERS + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_WAITERS);

   // input register
   logic              req_valid_ff;
   omfh_pkg::req_type req_ff;

   // mutex state
   logic [omfh_pkg::PID_W-1:0]    owner_ff, owner_in;
   logic [omfh_pkg::MISUSE_W-1:0] misuse_ff, misuse_in;

   // queue interface
   omfh_pkg::queue_ctl_type    q_ctl;
   logic [omfh_pkg::PID_W-1:0] q_head_pid;
   logic [CNT_W-1:0]           q_count;
   logic [CNT_W-1:0]           count_after;

   // result register
   logic              rsp_strobe_ff;
   omfh_pkg::rsp_type rsp_in, rsp_ff;

   // every word can be taken: the state update never holds the flow
   assign busy = 1'b0;

   // Decide the step for the registered request. Nothing moves unless a word waits.
   always_comb begin
      q_ctl       = '0;
      owner_in    = owner_ff;
      misuse_in   = misuse_ff;
      rsp_in      = '0;
      rsp_in.status = omfh_pkg::ST_OK;
      if (req_valid_ff) begin
         if (req_ff.func == omfh_pkg::FUNC_LOCK) begin
            if (!req_ff.process_valid || (req_ff.pid == '0)) begin
               rsp_in.status = omfh_pkg::ST_BAD_PROCESS;
            end else if (owner_ff == '0) begin
               // free mutex: take it at once
               owner_in = req_ff.pid;
            end else if (q_count != FULL_CNT) begin
               // held (possibly by this same pid): queue behind the owner
               q_ctl.push    = 1'b1;
               rsp_in.status = omfh_pkg::ST_BLOCKED;
            end else begin
               rsp_in.status = omfh_pkg::ST_BAD_PROCESS;
            end
         end else begin
            if (owner_ff == '0) begin
               // unlock of a free mutex: reject, no misuse count
               rsp_in.status = omfh_pkg::ST_NOT_OWNER;
            end else if (owner_ff != req_ff.pid) begin
               misuse_in     = misuse_ff + 1'b1;
               rsp_in.status = omfh_pkg::ST_NOT_OWNER;
            end else if (q_count == '0) begin
               // nobody waits: release
               owner_in = '0;
            end else begin
               // hand ownership to the queue head and report it as woken
               q_ctl.pop        = 1'b1;
               owner_in         = q_head_pid;
               rsp_in.woken_pid = q_head_pid;
            end
         end
      end

      count_after = q_count;
      if (q_ctl.push) begin
         count_after = q_count + 1'b1;
      end else if (q_ctl.pop) begin
         count_after = q_count - 1'b1;
      end

      rsp_in.owner_now    = owner_in;
      rsp_in.waiters_now  = omfh_pkg::COUNT_W'(count_after);
      rsp_in.misuse_total = misuse_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         owner_ff      <= '0;
         misuse_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= start && !busy;
         owner_ff      <= owner_in;
         misuse_ff     <= misuse_in;
         rsp_strobe_ff <= req_valid_ff;
      end
      // payload: hold no reset
      req_ff <= req_word;
      rsp_ff <= rsp_in;
   end

   omfh_queue #(
      .DEPTH (MAX_WAITERS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .push_pid (req_ff.pid),
      .head_pid (q_head_pid),
      .count    (q_count)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
